// ===== rtl/dpf_compare_share_eval_defines.svh =====
// Assertion macros for the dpf_compare_share_eval RTL.
// No dependencies; included by modules that carry assertions.
`ifndef DPF_COMPARE_SHARE_EVAL_DEFINES_SVH
`define DPF_COMPARE_SHARE_EVAL_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DCSE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define DCSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/dcse_pkg.sv =====
// Shared types, constants and AES-128 round functions for dpf_compare_share_eval.
// No dependencies.
package dcse_pkg;

  localparam int TdataInW  = 264;
  localparam int TdataOutW = 8;
  localparam logic [3:0] LastRound = 4'd10;

  typedef struct packed {
    logic [127:0] seed;
    logic [127:0] cw;
    logic         tcw_left;
    logic         tcw_right;
    logic         level_bit;
    logic         first_level;
    logic         last_level;
  } item_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // SubBytes then ShiftRows; byte i of the block sits at bits [8i+7:8i].
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] r;
    r = '0;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        r[8*(4*c+i) +: 8] = SBOX[s[8*(4*((c+i)%4)+i) +: 8]];
      end
    end
    return r;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s);
    logic [127:0] r;
    logic [7:0]   a0, a1, a2, a3, al;
    r = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = s[32*c +: 8];
      a1 = s[32*c+8 +: 8];
      a2 = s[32*c+16 +: 8];
      a3 = s[32*c+24 +: 8];
      al = a0 ^ a1 ^ a2 ^ a3;
      r[32*c +: 8]    = a0 ^ al ^ xtime(a0 ^ a1);
      r[32*c+8 +: 8]  = a1 ^ al ^ xtime(a1 ^ a2);
      r[32*c+16 +: 8] = a2 ^ al ^ xtime(a2 ^ a3);
      r[32*c+24 +: 8] = a3 ^ al ^ xtime(a3 ^ a0);
    end
    return r;
  endfunction

  // One step of the AES-128 key schedule.
  function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rcon);
    logic [31:0] t, w0, w1, w2, w3;
    t  = {SBOX[k[103:96]], SBOX[k[127:120]], SBOX[k[119:112]], SBOX[k[111:104]] ^ rcon};
    w0 = k[31:0] ^ t;
    w1 = k[63:32] ^ w0;
    w2 = k[95:64] ^ w1;
    w3 = k[127:96] ^ w2;
    return {w3, w2, w1, w0};
  endfunction

endpackage

// ===== rtl/dcse_front.sv =====
// Input side of dpf_compare_share_eval: unpacks stream items into a two-entry queue.
// Depends on dcse_pkg.
module dcse_front import dcse_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [TdataInW-1:0]  s_axis_tdata,
  input  logic                 s_axis_tuser,
  input  logic                 s_axis_tlast,
  output logic                 q_valid,
  output item_t                q_item,
  input  logic                 q_pop
);

  item_t      mem [2];
  logic       wptr, rptr;
  logic [1:0] cnt;
  logic       push;
  item_t      in_item;

  always_comb begin
    in_item.seed        = {s_axis_tdata[63:0], s_axis_tdata[127:64]};
    in_item.cw          = {s_axis_tdata[191:128], s_axis_tdata[255:192]};
    in_item.tcw_left    = s_axis_tdata[256];
    in_item.tcw_right   = s_axis_tdata[257];
    in_item.level_bit   = s_axis_tdata[258];
    in_item.first_level = s_axis_tuser;
    in_item.last_level  = s_axis_tlast;
  end

  assign s_axis_tready = (cnt != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign q_valid       = (cnt != 2'd0);
  assign q_item        = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= in_item;
    end
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (q_pop) rptr <= ~rptr;
      cnt <= cnt + 2'(push) - 2'(q_pop);
    end
  end

endmodule

// ===== rtl/dcse_back.sv =====
// AES-128 round sequencer and share logic of dpf_compare_share_eval.
// Depends on dcse_pkg and dpf_compare_share_eval_defines.svh.
`include "dpf_compare_share_eval_defines.svh"
module dcse_back import dcse_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic                 cfg_wdata,
  input  logic                 q_valid,
  input  item_t                q_item,
  output logic                 q_pop,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [TdataOutW-1:0] m_axis_tdata
);

  logic         party;
  logic         busy;
  logic [3:0]   round;
  logic [7:0]   rcon;
  logic [127:0] st, rk, cur_seed, it_cw;
  logic         ctrl_bit, prev_bit, gt_acc, lt_acc;
  logic         it_tcw, it_bit, it_last;
  logic [2:0]   res;

  logic [127:0] ss, rk_next, st_next, seed_new, key_in;
  logic         t_new, finishing, ctrl_now, c_in, gflip, lflip, g0, l0;

  always_comb begin
    ss       = sub_shift(st);
    rk_next  = key_step(rk, rcon);
    st_next  = ((round == LastRound) ? ss : mix_columns(ss)) ^ rk_next;
    t_new    = st_next[0] ^ (ctrl_bit & it_tcw);
    seed_new = {st_next[127:1], 1'b0} ^ (ctrl_bit ? it_cw : 128'd0);
    finishing = busy && (round == LastRound) && !(it_last && m_axis_tvalid && !m_axis_tready);
    q_pop    = q_valid && (!busy || finishing);
    ctrl_now = finishing ? t_new : ctrl_bit;
    key_in   = q_item.first_level ? q_item.seed : (finishing ? seed_new : cur_seed);
    c_in     = q_item.first_level ? party : ctrl_now;
    g0       = q_item.first_level ? 1'b0 : gt_acc;
    l0       = q_item.first_level ? 1'b0 : lt_acc;
    gflip    = q_item.first_level ? q_item.level_bit : (prev_bit != q_item.level_bit);
    lflip    = q_item.first_level ? !q_item.level_bit : (prev_bit != q_item.level_bit);
  end

  assign m_axis_tdata = {5'd0, res};

  always_ff @(posedge clk) begin
    if (rst) begin
      party         <= 1'b0;
      busy          <= 1'b0;
      round         <= 4'd0;
      rcon          <= 8'd0;
      cur_seed      <= '0;
      ctrl_bit      <= 1'b0;
      prev_bit      <= 1'b0;
      gt_acc        <= 1'b0;
      lt_acc        <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) party <= cfg_wdata;
      if (m_axis_tready) m_axis_tvalid <= 1'b0;
      if (busy && !(round == LastRound)) begin
        st    <= st_next;
        rk    <= rk_next;
        rcon  <= xtime(rcon);
        round <= round + 4'd1;
      end
      if (finishing) begin
        cur_seed <= seed_new;
        ctrl_bit <= t_new;
        busy     <= 1'b0;
        round    <= 4'd0;
        if (it_last) begin
          m_axis_tvalid <= 1'b1;
          res <= {lt_acc ^ (!it_bit & t_new), gt_acc ^ (it_bit & t_new), t_new};
        end
      end
      if (q_pop) begin
        st       <= {127'd0, q_item.level_bit} ^ key_in;
        rk       <= key_in;
        rcon     <= 8'h01;
        round    <= 4'd1;
        busy     <= 1'b1;
        ctrl_bit <= c_in;
        gt_acc   <= g0 ^ (gflip & c_in);
        lt_acc   <= l0 ^ (lflip & c_in);
        prev_bit <= q_item.level_bit;
        it_cw    <= q_item.cw;
        it_tcw   <= q_item.level_bit ? q_item.tcw_right : q_item.tcw_left;
        it_bit   <= q_item.level_bit;
        it_last  <= q_item.last_level;
      end
    end
  end

  `DCSE_ASSERT_NOW(a_idle_round, !busy, round == 4'd0, "idle with round count set")
  `DCSE_ASSERT_NOW(a_round_range, busy, (round != 4'd0) && (round <= LastRound), "round out of range")
  `DCSE_ASSERT_NEXT(a_pop_starts, q_pop, busy && (round == 4'd1), "pop did not start an item")

endmodule

// ===== rtl/dpf_compare_share_eval.sv =====
// Top level of dpf_compare_share_eval: DPF key-tree walk with comparison shares.
// Depends on dcse_pkg, dcse_front and dcse_back.
//
// Each input item is one level of one party's DPF key tree, x bit most significant
// first. The current 128-bit seed keys AES-128 over the block {64'b0, 63'b0, x bit};
// bit 0 of the ciphertext is the new control bit, the rest the next seed, and when the
// old control bit is 1 the level's correction word and the taken branch's tcw bit are
// XORed in. tuser = first_level restarts from the root seed and the party register;
// tlast = last_level returns one result: tdata bit 0 eq_share, bit 1 gt_share,
// bit 2 lt_share. The initial key add is folded into the edge that loads the item, then
// ten AES rounds run one per cycle on a single round unit with on-the-fly key schedule,
// since each level's key is the previous level's ciphertext; a last level's final round
// waits while an earlier result is held. A new item can start as the previous one ends.
// A two-entry queue takes items while the round unit works, and the result register
// lets the next level start while a result waits. Write party only while idle.
module dpf_compare_share_eval import dcse_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic                 cfg_wdata,       // party
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // seed_hi[63:0], seed_lo[127:64], cw_hi[191:128], cw_lo[255:192],
  // tcw_left[256], tcw_right[257], level_bit[258], zero fill
  input  logic [TdataInW-1:0]  s_axis_tdata,
  input  logic                 s_axis_tuser,    // first_level
  input  logic                 s_axis_tlast,    // last_level
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [TdataOutW-1:0] m_axis_tdata     // eq_share[0], gt_share[1], lt_share[2]
);

  logic  q_valid, q_pop;
  item_t q_item;

  // Hold incoming items until the round unit frees up.
  dcse_front u_front (
    .clk, .rst,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
    .q_valid, .q_item, .q_pop
  );

  // Advance the tree walk one level per item.
  dcse_back u_back (
    .clk, .rst, .cfg_we, .cfg_wdata,
    .q_valid, .q_item, .q_pop,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

endmodule

// ===== sim/tb_dpf_compare_share_eval.sv =====
// Self-checking testbench for dpf_compare_share_eval: DPF tree walks with comparison shares.
// Depends on dcse_pkg (port widths, S-box table) and the dpf_compare_share_eval RTL.
// A scoreboard class predicts each level with its own AES-128 and checks every result.
module tb_dpf_compare_share_eval;
  import dcse_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Predicts the share bits of each walk and holds the shares still to arrive.
  class share_scoreboard;
    bit          party;
    bit [127:0]  seed;
    bit          ctrl, prev_bit, gt_acc, lt_acc;
    bit [2:0]    shares_due[$];   // {lt, gt, eq}
    int          fails;

    function new();
      party = 0; seed = '0; ctrl = 0; prev_bit = 0; gt_acc = 0; lt_acc = 0; fails = 0;
    endfunction

    function automatic bit [7:0] gf_dbl(bit [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    // AES-128 encryption; byte i of key, block and output sits at bits [8i+7:8i].
    function automatic bit [127:0] aes_encrypt(bit [127:0] key, bit [127:0] blk);
      bit [7:0]   rk[176];
      bit [7:0]   st[16];
      bit [7:0]   sub[16];
      bit [7:0]   w[4];
      bit [7:0]   rc, a, a0, a1, a2, a3, al;
      bit [127:0] res;
      rc = 8'h01;
      for (int i = 0; i < 16; i++) rk[i] = key[8*i +: 8];
      for (int i = 16; i < 176; i += 4) begin
        for (int c = 0; c < 4; c++) w[c] = rk[i-4+c];
        if ((i % 16) == 0) begin
          a = w[0];
          w[0] = SBOX[w[1]] ^ rc;
          w[1] = SBOX[w[2]];
          w[2] = SBOX[w[3]];
          w[3] = SBOX[a];
          rc = gf_dbl(rc);
        end
        for (int c = 0; c < 4; c++) rk[i+c] = rk[i-16+c] ^ w[c];
      end
      for (int i = 0; i < 16; i++) st[i] = blk[8*i +: 8] ^ rk[i];
      for (int r = 1; r <= 10; r++) begin
        for (int c = 0; c < 4; c++)
          for (int i = 0; i < 4; i++) sub[4*c+i] = SBOX[st[4*((c+i)%4)+i]];
        if (r < 10) begin
          for (int c = 0; c < 4; c++) begin
            a0 = sub[4*c]; a1 = sub[4*c+1]; a2 = sub[4*c+2]; a3 = sub[4*c+3];
            al = a0 ^ a1 ^ a2 ^ a3;
            st[4*c]   = a0 ^ al ^ gf_dbl(a0 ^ a1);
            st[4*c+1] = a1 ^ al ^ gf_dbl(a1 ^ a2);
            st[4*c+2] = a2 ^ al ^ gf_dbl(a2 ^ a3);
            st[4*c+3] = a3 ^ al ^ gf_dbl(a3 ^ a0);
          end
        end else begin
          st = sub;
        end
        for (int i = 0; i < 16; i++) st[i] = st[i] ^ rk[16*r+i];
      end
      for (int i = 0; i < 16; i++) res[8*i +: 8] = st[i];
      return res;
    endfunction

    // Advance the walk by one accepted level; queue shares on the last level.
    function void note_level(bit [127:0] root, bit [127:0] cw, bit tcw_l, bit tcw_r,
                             bit xb, bit first, bit last);
      bit         gt_flip, lt_flip, t;
      bit [127:0] ct;
      if (first) begin
        seed = root; ctrl = party; gt_acc = 0; lt_acc = 0;
        gt_flip = xb; lt_flip = !xb;
      end else begin
        gt_flip = (prev_bit != xb); lt_flip = gt_flip;
      end
      if (gt_flip) gt_acc ^= ctrl;
      if (lt_flip) lt_acc ^= ctrl;
      prev_bit = xb;
      ct = aes_encrypt(seed, {127'b0, xb});
      t = ct[0];
      ct[0] = 1'b0;
      if (ctrl) begin
        ct ^= cw;
        t ^= xb ? tcw_r : tcw_l;
      end
      seed = ct;
      ctrl = t;
      if (last) shares_due.push_back({lt_acc ^ (xb ? 1'b0 : t), gt_acc ^ (xb ? t : 1'b0), t});
    endfunction

    function void check_shares(bit [7:0] got);
      bit [2:0] want;
      if (shares_due.size() == 0) begin
        $display("%0t: unexpected result, actual %h", $time, got);
        fails++;
        return;
      end
      want = shares_due.pop_front();
      if (got[0] != want[0]) begin
        $display("%0t: eq_share expected %b actual %b", $time, want[0], got[0]); fails++;
      end
      if (got[1] != want[1]) begin
        $display("%0t: gt_share expected %b actual %b", $time, want[1], got[1]); fails++;
      end
      if (got[2] != want[2]) begin
        $display("%0t: lt_share expected %b actual %b", $time, want[2], got[2]); fails++;
      end
    endfunction
  endclass

  logic                 clk = 0;
  logic                 rst = 1;
  logic                 cfg_we = 0;
  logic                 cfg_wdata = 0;
  logic                 s_axis_tvalid = 0;
  logic                 s_axis_tready;
  // seed_hi, seed_lo, cw_hi, cw_lo (64 each), tcw_left, tcw_right, level_bit, zero fill
  logic [TdataInW-1:0]  s_axis_tdata = '0;
  logic                 s_axis_tuser = 0;   // first_level
  logic                 s_axis_tlast = 0;   // last_level
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 0;
  logic [TdataOutW-1:0] m_axis_tdata;        // eq_share, gt_share, lt_share, zero fill

  share_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;    // long receiver hold-off, counted down by the receiver

  dpf_compare_share_eval DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
  );

  always #5 clk = ~clk;

  // Receiver: stall at random, or hold off completely while a long hold is running.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      m_axis_tready = 0;
      hold_cycles--;
    end else begin
      m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Check every result item at the edge that accepts it.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_shares(m_axis_tdata);
  end

  // Offer one level item, idling first at random; return once it is accepted.
  task automatic send_level(bit [127:0] root, bit [127:0] cw, bit tcw_l, bit tcw_r,
                            bit xb, bit first, bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      s_axis_tvalid = 0;
    end
    @(negedge clk);
    s_axis_tdata  = {5'b0, xb, tcw_r, tcw_l, cw[63:0], cw[127:64], root[63:0], root[127:64]};
    s_axis_tuser  = first;
    s_axis_tlast  = last;
    s_axis_tvalid = 1;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_level(root, cw, tcw_l, tcw_r, xb, first, last);
  endtask

  // Drop valid, wait for every share to arrive, then let the round unit go quiet.
  task automatic drain();
    @(negedge clk);
    s_axis_tvalid = 0;
    while (sb.shares_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_party(bit v);
    @(negedge clk);
    cfg_we = 1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 0;
    sb.party = v;
  endtask

  function automatic bit [127:0] rand128();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  // Random levels: mostly well-formed walks of random depth, the rest loose levels.
  task automatic random_levels(int n, bit long_hold, bit pause_mid);
    int sent, depth;
    bit hold_done;
    sent = 0;
    hold_done = 0;
    while (sent < n) begin
      if (!hold_done && sent >= n/2) begin
        hold_done = 1;
        if (long_hold) hold_cycles = 300;
        if (pause_mid) begin
          @(negedge clk);
          s_axis_tvalid = 0;
          while (sb.shares_due.size() != 0) @(posedge clk);
        end
      end
      if ($urandom_range(99) < 85) begin
        depth = ($urandom_range(19) == 0) ? $urandom_range(64, 33) : $urandom_range(12, 1);
        for (int i = 0; i < depth; i++)
          send_level(rand128(), rand128(), $urandom_range(1), $urandom_range(1),
                     $urandom_range(1), i == 0, i == depth - 1);
        sent += depth;
      end else begin
        send_level(rand128(), rand128(), $urandom_range(1), $urandom_range(1),
                   $urandom_range(1), $urandom_range(1), $urandom_range(1));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: walk straight out of reset with no first level, then field extremes.
    send_level('1, '1, 1, 1, 1, 0, 1);
    drain();
    write_party(0);
    send_level('0, '0, 0, 0, 0, 1, 1);
    send_level('1, '1, 1, 1, 1, 1, 1);
    send_level({64'h0, 64'h1}, '0, 0, 1, 0, 1, 1);       // root seed with bit 0 set
    send_level({64'h8000_0000_0000_0000, 64'h0}, {127'b0, 1'b1}, 1, 0, 1, 1, 0);
    send_level('0, {127'b0, 1'b1}, 1, 0, 0, 0, 0);       // correction word bit 0 set
    send_level('0, '1, 0, 1, 1, 0, 0);
    send_level('0, '1, 1, 1, 0, 0, 1);
    drain();
    write_party(1);
    for (int i = 0; i < 8; i++)
      send_level(rand128(), rand128(), i[0], i[1], i[2], i == 0, i == 7);
    send_level('1, '0, 1, 0, 0, 1, 1);
    send_level('0, '1, 0, 1, 1, 1, 1);
    send_level(rand128(), '1, 1, 1, 1, 1, 0);
    send_level(rand128(), '1, 1, 1, 1, 0, 1);
    drain();

    // Phase one: receiver mostly stalled, with one long hold-off.
    send_idle_pct = 15; recv_idle_pct = 67;
    random_levels(500, 1, 0);
    drain();
    write_party(0);

    // Phase two: sender mostly idle, with one pause until all shares are back.
    send_idle_pct = 67; recv_idle_pct = 15;
    random_levels(500, 0, 1);
    drain();
    write_party(1);

    // Phase three: full rate on both sides.
    send_idle_pct = 0; recv_idle_pct = 0;
    random_levels(430, 0, 0);
    drain();

    if (sb.fails == 0 && sb.shares_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/dcse_pkg.sv
rtl/dcse_front.sv
rtl/dcse_back.sv
rtl/dpf_compare_share_eval.sv
sim/tb_dpf_compare_share_eval.sv
